/* hw/rtl/mro_pkg.sv */
// ----------------------------------------------------------------------------
// mro_pkg: shared types and constants of the mixed radix odometer
// Opcodes, configuration register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mro_pkg;

  // Default parameter values
  localparam int unsigned NUM_WHEELS_DEF  = 6;
  localparam int unsigned WHEEL_BITS_DEF  = 16;

  // Fixed field widths
  localparam int unsigned REG_WHEELS      = 6;   // radix registers, output wheels
  localparam int unsigned RADIX_W         = 16;
  localparam int unsigned VAL_W           = 16;
  localparam int unsigned STEP_W          = 31;
  localparam int unsigned DIVC_W          = 5;   // divider step counter
  localparam int unsigned CNT_W           = 3;   // wheel count and wheel pointer
  localparam int unsigned WIDX_W          = 3;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;

  // Reset values of the configuration registers
  localparam int unsigned WHEEL_COUNT_RST = 6;
  localparam int unsigned RADIX_RST       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADVANCE = 2'd0,
    OP_REVERSE = 2'd1,
    OP_SET     = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_COUNT = 3'd0,
    CFG_RADIX_0     = 3'd1,
    CFG_RADIX_1     = 3'd2,
    CFG_RADIX_2     = 3'd3,
    CFG_RADIX_3     = 3'd4,
    CFG_RADIX_4     = 3'd5,
    CFG_RADIX_5     = 3'd6
  } cfg_reg_e;

endpackage

`default_nettype wire

/* hw/rtl/mixed_radix_odometer_unit.sv */
// ----------------------------------------------------------------------------
// mixed_radix_odometer_unit: mixed radix counter of up to six wheels
// Advance, reverse, set one wheel or clear all; one result beat per item.
// ----------------------------------------------------------------------------
// One item at a time. An item first visits every wheel once; a wheel in use
// whose setting is not below its radix, left so by a radix change, is reduced
// through the shared divider. Set and clear then act in S_EXEC and finish in
// S_DONE. Advance and reverse walk the wheels in use: a wheel goes straight to
// its update while the remaining step balance is zero and through the divider
// otherwise, since balance / radix and balance % radix come from one shared
// restoring divider that retires one quotient bit per cycle over 31 bits. The
// result sits in an output register, so the next item is taken while a
// result waits.
`default_nettype none

module mixed_radix_odometer_unit #(
  parameter int unsigned NUM_WHEELS = mro_pkg::NUM_WHEELS_DEF,
  parameter int unsigned WHEEL_BITS = mro_pkg::WHEEL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mro_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mro_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mro_pkg::OP_W-1:0]       opcode_i,
  input  logic [mro_pkg::STEP_W-1:0]     step_count_i,
  input  logic [mro_pkg::WIDX_W-1:0]     wheel_index_i,
  input  logic [mro_pkg::VAL_W-1:0]      wheel_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mro_pkg::VAL_W-1:0]      wheel_value_0_o,
  output logic [mro_pkg::VAL_W-1:0]      wheel_value_1_o,
  output logic [mro_pkg::VAL_W-1:0]      wheel_value_2_o,
  output logic [mro_pkg::VAL_W-1:0]      wheel_value_3_o,
  output logic [mro_pkg::VAL_W-1:0]      wheel_value_4_o,
  output logic [mro_pkg::VAL_W-1:0]      wheel_value_5_o,
  output logic                           error_flag_o
);
  import mro_pkg::*;

  localparam int unsigned WB = WHEEL_BITS;
  localparam int unsigned W1 = WB + 1;
  localparam int unsigned W2 = WB + 2;
  localparam logic [RADIX_W-1:0] RMAX = RADIX_W'((32'd1 << WB) - 32'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_DIV,
    S_EXEC,
    S_MOVE,
    S_UPD,
    S_DONE
  } state_e;

  function automatic logic [WB-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    if (r == '0) begin
      return WB'(1);
    end else if (r > RMAX) begin
      return RMAX[WB-1:0];
    end else begin
      return r[WB-1:0];
    end
  endfunction

  // Configuration
  logic [CNT_W-1:0]   wcount_q;
  logic [RADIX_W-1:0] radix_q [REG_WHEELS];

  // Wheel state
  logic [WB-1:0]      wheel_q [NUM_WHEELS];

  // Sequencer and item
  state_e             state_q;
  op_e                op_q;
  logic [WIDX_W-1:0]  idx_q;
  logic [VAL_W-1:0]   val_q;
  logic [CNT_W-1:0]   n_q;
  logic [CNT_W-1:0]   ptr_q;
  logic [STEP_W-1:0]  bal_q;
  logic               carry_q;
  logic [WB-1:0]      d_q;
  logic               err_q;

  // Shared divider
  logic [STEP_W-1:0]  quo_q;
  logic [WB-1:0]      rem_q;
  logic [DIVC_W-1:0]  cnt_q;
  logic               div_move_q;

  // Output register
  logic               out_valid_q;
  logic               out_err_q;
  logic [VAL_W-1:0]   out_q [REG_WHEELS];

  // Combinational
  logic [CNT_W-1:0]   n_use;
  logic [WB-1:0]      cur_s;
  logic [WB-1:0]      cur_r;
  logic [WB-1:0]      set_r;
  logic               set_ok;
  logic [W1-1:0]      rem_sh;
  logic [W2-1:0]      div_diff;
  logic               div_ge;
  logic [WB-1:0]      rem_nx;
  logic [STEP_W-1:0]  quo_nx;
  logic               div_last;
  logic [W1-1:0]      fwd_sum;
  logic [W1-1:0]      fwd_sub;
  logic               fwd_ge;
  logic [W1-1:0]      need;
  logic [W1-1:0]      rev_sub;
  logic [W1-1:0]      rev_wrap;
  logic               rev_ok;
  logic [WB-1:0]      upd_s;
  logic               upd_c;
  logic               w_we;
  logic [CNT_W-1:0]   w_idx;
  logic [WB-1:0]      w_data;
  logic               w_clear;
  logic               out_load;
  logic [VAL_W-1:0]   out_d [REG_WHEELS];

  always_comb begin
    if (wcount_q == '0) begin
      n_use = CNT_W'(1);
    end else if (wcount_q > CNT_W'(NUM_WHEELS)) begin
      n_use = CNT_W'(NUM_WHEELS);
    end else begin
      n_use = wcount_q;
    end
  end

  // Wheel and radix under the pointer; out-of-range pointer reads a zero wheel and a radix of one
  always_comb begin
    cur_s = '0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (ptr_q == CNT_W'(i)) cur_s = wheel_q[i];
    end
    cur_r = WB'(1);
    set_r = WB'(1);
    for (int i = 0; i < REG_WHEELS; i++) begin
      if (ptr_q == CNT_W'(i)) cur_r = eff_radix(radix_q[i]);
      if (idx_q == WIDX_W'(i)) set_r = eff_radix(radix_q[i]);
    end
  end

  assign set_ok = (CNT_W'(idx_q) < n_q) && (val_q < VAL_W'(set_r));

  // One restoring division step
  assign rem_sh   = {rem_q, quo_q[STEP_W-1]};
  assign div_diff = {1'b0, rem_sh} - {2'b0, cur_r};
  assign div_ge   = ~div_diff[W2-1];
  assign rem_nx   = div_ge ? div_diff[WB-1:0] : rem_sh[WB-1:0];
  assign quo_nx   = {quo_q[STEP_W-2:0], div_ge};
  assign div_last = (cnt_q == DIVC_W'(STEP_W - 1));

  // Digit add with carry, digit subtract with borrow
  assign fwd_sum  = {1'b0, cur_s} + {1'b0, d_q} + W1'(carry_q);
  assign fwd_sub  = fwd_sum - {1'b0, cur_r};
  assign fwd_ge   = fwd_sum >= {1'b0, cur_r};
  assign need     = {1'b0, d_q} + W1'(carry_q);
  assign rev_ok   = {1'b0, cur_s} >= need;
  assign rev_sub  = {1'b0, cur_s} - need;
  assign rev_wrap = {1'b0, cur_s} + {1'b0, cur_r} - need;

  always_comb begin
    if (op_q == OP_REVERSE) begin
      upd_s = rev_ok ? rev_sub[WB-1:0] : rev_wrap[WB-1:0];
      upd_c = ~rev_ok;
    end else begin
      upd_s = fwd_ge ? fwd_sub[WB-1:0] : fwd_sum[WB-1:0];
      upd_c = fwd_ge;
    end
  end

  // Single write port into the wheel registers
  always_comb begin
    w_we    = 1'b0;
    w_idx   = ptr_q;
    w_data  = '0;
    w_clear = 1'b0;
    case (state_q)
      S_NORM: begin
        w_we = (ptr_q < CNT_W'(NUM_WHEELS)) && (ptr_q >= n_q);
      end
      S_DIV: begin
        w_we   = div_last && !div_move_q;
        w_data = rem_nx;
      end
      S_UPD: begin
        w_we   = 1'b1;
        w_data = upd_s;
      end
      S_EXEC: begin
        if (op_q == OP_SET) begin
          w_we   = set_ok;
          w_idx  = CNT_W'(idx_q);
          w_data = val_q[WB-1:0];
        end
        w_clear = (op_q == OP_CLEAR);
      end
      default: begin
      end
    endcase
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    for (int i = 0; i < REG_WHEELS; i++) out_d[i] = '0;
    for (int i = 0; i < NUM_WHEELS; i++) out_d[i] = VAL_W'(wheel_q[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcount_q    <= CNT_W'(WHEEL_COUNT_RST);
      for (int i = 0; i < REG_WHEELS; i++) begin
        radix_q[i] <= RADIX_W'(RADIX_RST);
        out_q[i]   <= '0;
      end
      for (int i = 0; i < NUM_WHEELS; i++) wheel_q[i] <= '0;
      state_q     <= S_IDLE;
      op_q        <= OP_ADVANCE;
      idx_q       <= '0;
      val_q       <= '0;
      n_q         <= '0;
      ptr_q       <= '0;
      bal_q       <= '0;
      carry_q     <= 1'b0;
      d_q         <= '0;
      err_q       <= 1'b0;
      quo_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      div_move_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_WHEEL_COUNT: wcount_q   <= cfg_wdata_i[CNT_W-1:0];
          CFG_RADIX_0:     radix_q[0] <= cfg_wdata_i;
          CFG_RADIX_1:     radix_q[1] <= cfg_wdata_i;
          CFG_RADIX_2:     radix_q[2] <= cfg_wdata_i;
          CFG_RADIX_3:     radix_q[3] <= cfg_wdata_i;
          CFG_RADIX_4:     radix_q[4] <= cfg_wdata_i;
          CFG_RADIX_5:     radix_q[5] <= cfg_wdata_i;
          default: begin
          end
        endcase
      end

      for (int i = 0; i < NUM_WHEELS; i++) begin
        if (w_clear) begin
          wheel_q[i] <= '0;
        end else if (w_we && (w_idx == CNT_W'(i))) begin
          wheel_q[i] <= w_data;
        end
      end

      // A new result may replace the one leaving in the same cycle
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= op_e'(opcode_i);
            bal_q   <= step_count_i;
            idx_q   <= wheel_index_i;
            val_q   <= wheel_value_i;
            n_q     <= n_use;
            ptr_q   <= '0;
            err_q   <= 1'b0;
            state_q <= S_NORM;
          end
        end
        // Clear unused wheels, reduce stale ones
        S_NORM: begin
          if (ptr_q == CNT_W'(NUM_WHEELS)) begin
            ptr_q   <= '0;
            carry_q <= 1'b0;
            state_q <= S_EXEC;
          end else if (ptr_q < n_q && cur_s >= cur_r) begin
            quo_q      <= STEP_W'(cur_s);
            rem_q      <= '0;
            cnt_q      <= '0;
            div_move_q <= 1'b0;
            state_q    <= S_DIV;
          end else begin
            ptr_q <= ptr_q + CNT_W'(1);
          end
        end
        S_DIV: begin
          quo_q <= quo_nx;
          rem_q <= rem_nx;
          cnt_q <= cnt_q + DIVC_W'(1);
          if (div_last) begin
            if (div_move_q) begin
              bal_q   <= quo_nx;
              d_q     <= rem_nx;
              state_q <= S_UPD;
            end else begin
              ptr_q   <= ptr_q + CNT_W'(1);
              state_q <= S_NORM;
            end
          end
        end
        S_EXEC: begin
          case (op_q)
            OP_ADVANCE, OP_REVERSE: state_q <= S_MOVE;
            OP_SET: begin
              err_q   <= ~set_ok;
              state_q <= S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_MOVE: begin
          if (ptr_q == n_q) begin
            state_q <= S_DONE;
          end else if (bal_q == '0) begin
            d_q     <= '0;
            state_q <= S_UPD;
          end else begin
            quo_q      <= bal_q;
            rem_q      <= '0;
            cnt_q      <= '0;
            div_move_q <= 1'b1;
            state_q    <= S_DIV;
          end
        end
        S_UPD: begin
          carry_q <= upd_c;
          ptr_q   <= ptr_q + CNT_W'(1);
          state_q <= S_MOVE;
        end
        S_DONE: begin
          if (out_load) begin
            for (int i = 0; i < REG_WHEELS; i++) out_q[i] <= out_d[i];
            out_err_q   <= err_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign wheel_value_0_o = out_q[0];
  assign wheel_value_1_o = out_q[1];
  assign wheel_value_2_o = out_q[2];
  assign wheel_value_3_o = out_q[3];
  assign wheel_value_4_o = out_q[4];
  assign wheel_value_5_o = out_q[5];
  assign error_flag_o    = out_err_q;

  // Assertions
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_NORM)
    else $error("accepted beat did not start the wheel sweep");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q < DIVC_W'(STEP_W))
    else $error("divider ran past its last step");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> d_q < cur_r)
    else $error("digit not below the wheel radix");

  a_move_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOVE |-> ptr_q <= n_q)
    else $error("move pointer beyond the wheels in use");

  a_err_only_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && err_q |-> op_q == OP_SET)
    else $error("error flag raised by an operation other than set");

endmodule

`default_nettype wire
